[design/euclidean_signed_divider_defines.svh]
// ----------------------------------------------------------------------------
// euclidean_signed_divider_defines
// Assertion macros used by the checker file of the divider.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_SIGNED_DIVIDER_DEFINES_SVH
`define EUCLIDEAN_SIGNED_DIVIDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ESD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/esd_pkg.sv]
// ----------------------------------------------------------------------------
// esd_pkg
// Status codes and the control bundle that rides along the divider pipeline.
// ----------------------------------------------------------------------------
package esd_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_DIV_ZERO = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

	// Operand flags captured at entry and carried to the correction stage
	typedef struct packed {
		logic zero;   // divisor is zero
		logic ovf;    // most negative dividend over minus one
		logic an;     // dividend negative
		logic bn;     // divisor negative
	} ctl_t;

endpackage

[design/esd_prep.sv]
// ----------------------------------------------------------------------------
// esd_prep
// Entry stage: takes operand magnitudes and flags the special cases.
// ----------------------------------------------------------------------------
module esd_prep #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  valid_s1,
	output logic [DATA_WIDTH-1:0] am_s1,
	output logic [DATA_WIDTH-1:0] bm_s1,
	output esd_pkg::ctl_t         ctl_s1
);

	localparam logic [DATA_WIDTH-1:0] SIGN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] ONES_VAL = {DATA_WIDTH{1'b1}};

	esd_pkg::ctl_t ctl_d;

	always_comb begin
		ctl_d.an   = a[DATA_WIDTH-1];
		ctl_d.bn   = b[DATA_WIDTH-1];
		ctl_d.zero = (b == '0);
		ctl_d.ovf  = (a == SIGN_VAL) && (b == ONES_VAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		am_s1  <= ctl_d.an ? (~a + 1'b1) : a;
		bm_s1  <= ctl_d.bn ? (~b + 1'b1) : b;
		ctl_s1 <= ctl_d;
	end

endmodule

[design/esd_step.sv]
// ----------------------------------------------------------------------------
// esd_step
// One restoring division step: one quotient bit per stage, registered.
// ----------------------------------------------------------------------------
module esd_step #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_i,
	input  logic [DATA_WIDTH-1:0] rem_i,
	input  logic [DATA_WIDTH-1:0] aq_i,
	input  logic [DATA_WIDTH-1:0] bm_i,
	input  esd_pkg::ctl_t         ctl_i,
	output logic                  valid_sn,
	output logic [DATA_WIDTH-1:0] rem_sn,
	output logic [DATA_WIDTH-1:0] aq_sn,
	output logic [DATA_WIDTH-1:0] bm_sn,
	output esd_pkg::ctl_t         ctl_sn
);

	// Partial remainder stays below the divisor magnitude, so the shift fits
	logic [DATA_WIDTH-1:0] shifted;
	logic [DATA_WIDTH:0]   diff;
	logic                  ge;

	always_comb begin
		shifted = {rem_i[DATA_WIDTH-2:0], aq_i[DATA_WIDTH-1]};
		diff    = {1'b0, shifted} - {1'b0, bm_i};
		ge      = !diff[DATA_WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else begin
			valid_sn <= valid_i;
		end
	end

	// Shift the quotient bit into the low end as the dividend bits leave the top
	always_ff @(posedge clk) begin
		rem_sn <= ge ? diff[DATA_WIDTH-1:0] : shifted;
		aq_sn  <= {aq_i[DATA_WIDTH-2:0], ge};
		bm_sn  <= bm_i;
		ctl_sn <= ctl_i;
	end

endmodule

[design/esd_fix.sv]
// ----------------------------------------------------------------------------
// esd_fix
// Output stage: applies signs, Euclidean correction and the special cases.
// ----------------------------------------------------------------------------
module esd_fix #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_i,
	input  logic [DATA_WIDTH-1:0] q0_i,
	input  logic [DATA_WIDTH-1:0] r0_i,
	input  logic [DATA_WIDTH-1:0] bm_i,
	input  esd_pkg::ctl_t         ctl_i,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-2:0] remainder,
	output esd_pkg::status_t      status
);

	localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	logic [DATA_WIDTH-1:0] q_d;
	logic [DATA_WIDTH-1:0] r_d;
	esd_pkg::status_t      st_d;
	logic                  adjust;

	always_comb begin
		adjust = ctl_i.an && (r0_i != '0);
		priority if (ctl_i.zero) begin
			q_d  = '0;
			r_d  = '0;
			st_d = esd_pkg::ST_DIV_ZERO;
		end else if (ctl_i.ovf) begin
			q_d  = MAX_POS;
			r_d  = '0;
			st_d = esd_pkg::ST_OVERFLOW;
		end else if (adjust) begin
			// Negative remainder: step the quotient away from zero by the divisor sign
			q_d  = ctl_i.bn ? (q0_i + 1'b1) : ~q0_i;
			r_d  = bm_i - r0_i;
			st_d = esd_pkg::ST_OK;
		end else begin
			q_d  = (ctl_i.an ^ ctl_i.bn) ? (~q0_i + 1'b1) : q0_i;
			r_d  = r0_i;
			st_d = esd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		quotient  <= q_d;
		remainder <= r_d[DATA_WIDTH-2:0];
		status    <= st_d;
	end

endmodule

[design/euclidean_signed_divider.sv]
// ----------------------------------------------------------------------------
// euclidean_signed_divider
// Pipelined signed Euclidean divider, one operand pair per clock.
//
//   channel   handshake              payload
//   input     start (busy low)       dividend, divisor
//   result    done strobe, 1 cycle   quotient, remainder, status
//
// A new pair is taken every cycle; busy stays low.
// The pipeline has one entry stage, one restoring
// compare-subtract stage per quotient bit and one correction/output stage.
// Reset clears the valid bits of every stage; payload registers are not reset.
// The result is shown for one cycle only and the pipeline never holds.
// ----------------------------------------------------------------------------
module euclidean_signed_divider #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] dividend,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] quotient,
	output logic        [DATA_WIDTH-2:0] remainder,
	output logic        [1:0]            status
);

	logic                  valid_c [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] rem_c   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] aq_c    [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] bm_c    [DATA_WIDTH+1];
	esd_pkg::ctl_t         ctl_c   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] q_out;

	assign busy     = 1'b0;
	assign rem_c[0] = '0;

	esd_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.a        ($unsigned(dividend)),
		.b        ($unsigned(divisor)),
		.valid_s1 (valid_c[0]),
		.am_s1    (aq_c[0]),
		.bm_s1    (bm_c[0]),
		.ctl_s1   (ctl_c[0])
	);

	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
		esd_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_i  (valid_c[k]),
			.rem_i    (rem_c[k]),
			.aq_i     (aq_c[k]),
			.bm_i     (bm_c[k]),
			.ctl_i    (ctl_c[k]),
			.valid_sn (valid_c[k+1]),
			.rem_sn   (rem_c[k+1]),
			.aq_sn    (aq_c[k+1]),
			.bm_sn    (bm_c[k+1]),
			.ctl_sn   (ctl_c[k+1])
		);
	end

	esd_fix #(.DATA_WIDTH(DATA_WIDTH)) u_fix (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_i   (valid_c[DATA_WIDTH]),
		.q0_i      (aq_c[DATA_WIDTH]),
		.r0_i      (rem_c[DATA_WIDTH]),
		.bm_i      (bm_c[DATA_WIDTH]),
		.ctl_i     (ctl_c[DATA_WIDTH]),
		.done      (done),
		.quotient  (q_out),
		.remainder (remainder),
		.status    (status)
	);

	assign quotient = $signed(q_out);

endmodule

[design/esd_checker.sv]
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks of the divider's result channel and timing.
// ----------------------------------------------------------------------------
`include "euclidean_signed_divider_defines.svh"

module esd_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic signed [DATA_WIDTH-1:0] quotient,
	input logic        [DATA_WIDTH-2:0] remainder,
	input logic        [1:0]            status
);

	localparam int LATENCY = DATA_WIDTH + 2;
	localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	`ESD_ASSERT_NOW(a_never_busy, 1'b1, !busy, "busy raised on a pipeline that never holds")
	`ESD_ASSERT_NOW(a_done_has_start, done, $past(start, LATENCY),
		"result strobe without a transaction at the input")
	`ESD_ASSERT_NOW(a_zero_div, done && (status == esd_pkg::ST_DIV_ZERO),
		(quotient == '0) && (remainder == '0), "divide by zero result not cleared")
	`ESD_ASSERT_NOW(a_overflow, done && (status == esd_pkg::ST_OVERFLOW),
		($unsigned(quotient) == MAX_POS) && (remainder == '0),
		"overflow result not saturated")
	`ESD_ASSERT_NOW(a_status_code, done,
		(status == esd_pkg::ST_OK) || (status == esd_pkg::ST_DIV_ZERO) ||
		(status == esd_pkg::ST_OVERFLOW), "undefined status code")

endmodule

bind euclidean_signed_divider esd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_esd_checker (.*);

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed Euclidean divider. Operand pairs go in
// through the start/busy handshake with random or no gaps. A bench model works
// out quotient, remainder and status for each accepted transaction and queues
// them. Every done strobe is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module tb;

	localparam int DW         = 32;
	localparam int LATENCY    = DW + 2;
	localparam int MAX_CYCLES = 400000;
	localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};

	typedef struct {
		logic signed [DW-1:0] quo;
		logic        [DW-2:0] rem;
		esd_pkg::status_t     st;
	} div_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 start    = 1'b0;
	logic signed [DW-1:0] dividend = '0;
	logic signed [DW-1:0] divisor  = '0;
	logic                 busy;
	logic                 done;
	logic signed [DW-1:0] quotient;
	logic        [DW-2:0] remainder;
	logic        [1:0]    status;

	div_result_t pending_divisions[$];
	int          errors  = 0;
	int          max_gap = 18;

	always #5 clk = ~clk;

	euclidean_signed_divider #(
		.DATA_WIDTH(DW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (done),
		.quotient (quotient),
		.remainder(remainder),
		.status   (status)
	);

	// Floor toward minus infinity for positive divisors, ceiling for negative ones,
	// so the remainder never goes negative.
	function automatic div_result_t euclid_divide(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		div_result_t   res;
		logic          a_neg;
		logic          b_neg;
		logic [DW-1:0] a_mag;
		logic [DW-1:0] b_mag;
		logic [DW-1:0] q_trunc;
		logic [DW-1:0] r_trunc;
		logic [DW-1:0] q_fix;
		logic [DW-1:0] r_fix;
		res.quo = '0;
		res.rem = '0;
		res.st  = esd_pkg::ST_OK;
		if (b == '0) begin
			res.st = esd_pkg::ST_DIV_ZERO;
		end else if (a == S_MIN && b == '1) begin
			res.quo = S_MAX;
			res.st  = esd_pkg::ST_OVERFLOW;
		end else begin
			a_neg   = a[DW-1];
			b_neg   = b[DW-1];
			a_mag   = a_neg ? -a : a;
			b_mag   = b_neg ? -b : b;
			q_trunc = a_mag / b_mag;
			r_trunc = a_mag % b_mag;
			if (!a_neg) begin
				q_fix = b_neg ? -q_trunc : q_trunc;
				r_fix = r_trunc;
			end else if (r_trunc == '0) begin
				q_fix = b_neg ? q_trunc : -q_trunc;
				r_fix = '0;
			end else if (!b_neg) begin
				q_fix = -q_trunc - 1'b1;
				r_fix = b_mag - r_trunc;
			end else begin
				q_fix = q_trunc + 1'b1;
				r_fix = b_mag - r_trunc;
			end
			res.quo = q_fix;
			res.rem = r_fix[DW-2:0];
		end
		return res;
	endfunction

	// Mix of edge values, full-range words and short magnitudes of either sign
	function automatic logic signed [DW-1:0] rand_operand();
		logic signed [DW-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 11))
			0: v = S_MIN;
			1: v = S_MAX;
			2: v = '0;
			3: v = '1;
			4: v = 1;
			5, 6: ;
			default: v = v >>> $urandom_range(1, DW - 1);
		endcase
		return v;
	endfunction

	// Idle a random number of cycles with junk on the operand lines, then hold
	// start until the transaction is taken.
	task automatic send_pair(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) begin
				dividend <= $urandom;
				divisor  <= $urandom;
				@(posedge clk);
			end
		end
		start    <= 1'b1;
		dividend <= a;
		divisor  <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_divisions.push_back(euclid_divide(a, b));
	endtask

	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_divisions.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic test_directed_corners();
		logic signed [DW-1:0] a_list[$];
		logic signed [DW-1:0] b_list[$];
		a_list = '{0, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, -1, 7, -7, 7, -7, -6, -6,
			S_MIN, 5, S_MIN, 0, S_MIN, S_MAX, -1, 1, -1, S_MIN + 1, S_MAX, -5};
		b_list = '{1, 1, 1, S_MAX, S_MIN, S_MIN, S_MIN, 2, 2, -2, -2, 3, -3,
			-1, 0, 0, 0, -2, -1, -1, S_MAX, S_MAX, -1, S_MAX, 3};
		max_gap = 18;
		foreach (a_list[i])
			send_pair(a_list[i], b_list[i]);
	endtask

	task automatic test_random_operands(input int count);
		max_gap = 18;
		repeat (count)
			send_pair(rand_operand(), rand_operand());
	endtask

	// One side pinned near a sign or range boundary, the other random
	task automatic test_sign_boundaries(input int count);
		logic signed [DW-1:0] edge_vals[$];
		logic signed [DW-1:0] pick;
		edge_vals = '{S_MIN, S_MIN + 1, S_MAX, S_MAX - 1, -1, 1, 0, -2, 2};
		max_gap = 18;
		repeat (count) begin
			pick = edge_vals[$urandom_range(0, edge_vals.size() - 1)];
			if ($urandom_range(0, 1))
				send_pair(pick, rand_operand());
			else
				send_pair(rand_operand(), pick);
		end
	endtask

	// Back-to-back transactions, no idle cycles
	task automatic test_full_rate(input int count);
		max_gap = 0;
		repeat (count)
			send_pair(rand_operand(), rand_operand());
		max_gap = 18;
	endtask

	always @(posedge clk) begin
		div_result_t want;
		if (arst_n && done) begin
			if (pending_divisions.size() == 0) begin
				$error("unexpected result: quotient %0d remainder %0d status %0d",
					quotient, remainder, status);
				errors++;
			end else begin
				want = pending_divisions.pop_front();
				if (quotient !== want.quo) begin
					$error("quotient: expected %0d, got %0d", want.quo, quotient);
					errors++;
				end
				if (remainder !== want.rem) begin
					$error("remainder: expected %0d, got %0d", want.rem, remainder);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
			end
		end
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < MAX_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("euclidean_signed_divider test failed");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_corners();
		drain_pipeline();
		test_random_operands(700);
		drain_pipeline();
		test_sign_boundaries(250);
		test_full_rate(280);
		drain_pipeline();
		if (errors == 0)
			$display("euclidean_signed_divider test passed");
		else
			$display("euclidean_signed_divider test failed");
		$finish;
	end

endmodule
